// ----- rtl/dqti_pkg.sv -----
// Shared types and constants for the delta-queue timer insert block.
// Command and status bundles between controller and datapath, result codes.
// No dependencies.
package dqti_pkg;

	typedef logic [1:0] status_code_t;

	localparam status_code_t ST_SCHEDULED = 2'd0;
	localparam status_code_t ST_BAD_ARGS  = 2'd1;
	localparam status_code_t ST_FULL      = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture the request beat
		logic probe;  // one round-robin probe of the used flags
		logic rd;     // read delta and link of the current successor
		logic step;   // move the walk one entry on
		logic link;   // write the new entry and, if first, the head link
		logic fixup;  // patch predecessor link and successor delta
		logic emit;   // load the output register
	} dqti_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad_args;   // request on the slave port is rejected
		logic found;      // current probe hits a free slot
		logic exhausted;  // last probe missed
		logic at_null;    // walk reached the end of the list
		logic fits;       // successor delta <= remaining time
		logic out_busy;   // output register holds an untaken beat
	} dqti_stat_t;

endpackage

// ----- rtl/dqti_ctrl.sv -----
// Sequencing state machine for the delta-queue timer insert block.
// Drives dqti_cmd_t towards the datapath, reads dqti_stat_t back; uses dqti_pkg.
module dqti_ctrl import dqti_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dqti_stat_t stat,
	output dqti_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SEARCH = 7'b0000010,
		S_READ   = 7'b0000100,
		S_CHECK  = 7'b0001000,
		S_LINK   = 7'b0010000,
		S_FIXUP  = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.bad_args ? S_RESP : S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.probe = 1'b1;
				if (stat.found)
					state_d = S_READ;
				else if (stat.exhausted)
					state_d = S_RESP;
			end
			S_READ: begin
				if (stat.at_null) begin
					state_d = S_LINK;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.fits) begin
					cmd.step = 1'b1;
					state_d  = S_READ;
				end else begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d  = S_FIXUP;
			end
			S_FIXUP: begin
				cmd.fixup = 1'b1;
				state_d   = S_RESP;
			end
			S_RESP: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- rtl/dqti_dpath.sv -----
// Datapath of the delta-queue timer insert block: used flags, allocation cursor,
// link and delta memories, walk registers and the output register. Uses dqti_pkg.
module dqti_dpath import dqti_pkg::*; #(
	parameter int EVENT_SLOTS = 32,
	parameter int HEAD_SLOT   = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  dqti_cmd_t    cmd,
	output dqti_stat_t   stat,
	input  logic [39:0]  in_data,
	input  logic [8:0]   in_user,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [71:0]  out_data,
	output logic [2:0]   out_user
);

	localparam int SW = $clog2(EVENT_SLOTS);
	localparam int LW = $clog2(EVENT_SLOTS + 1);
	localparam int XW = SW + 5;
	localparam logic [SW-1:0] HEAD_IDX  = SW'(HEAD_SLOT % EVENT_SLOTS);
	localparam logic [SW-1:0] LAST_IDX  = SW'(EVENT_SLOTS - 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(EVENT_SLOTS);

	// control state
	logic [EVENT_SLOTS-1:0] used_q;
	logic [SW-1:0]          cursor_q;
	logic [SW-1:0]          probe_cnt_q;
	logic [LW-1:0]          head_link_q;
	logic                   out_valid_q;

	// payload
	status_code_t  stat_q;
	logic [30:0]   time_q;
	logic [30:0]   start_q;
	logic [7:0]    conn_q;
	logic [7:0]    type_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] prev_q;
	logic [LW-1:0] nxt_q;
	logic [30:0]   rem_rd_q;
	logic [LW-1:0] link_rd_q;
	logic [30:0]   succ_q;
	logic [71:0]   out_data_q;
	logic [2:0]    out_user_q;

	logic [30:0] rem_mem   [EVENT_SLOTS];
	logic [LW-1:0] link_mem [EVENT_SLOTS];
	logic [46:0] rec_mem   [EVENT_SLOTS];

	logic [SW-1:0] cand;
	logic          found;
	logic          nxt_null;
	logic [SW-1:0] nxt_idx;
	logic [30:0]   succ_new;
	logic          ok;
	logic [XW-1:0] slot_ext, prev_ext;
	logic          bad_args;

	assign cand     = (cursor_q == LAST_IDX) ? '0 : cursor_q + 1'b1;
	assign found    = (cand != HEAD_IDX) && !used_q[cand];
	assign nxt_null = (nxt_q == NULL_LINK);
	assign nxt_idx  = nxt_q[SW-1:0];
	assign succ_new = rem_rd_q - time_q;
	assign bad_args = in_data[31] || !in_user[0];
	assign ok       = (stat_q == ST_SCHEDULED);
	assign slot_ext = XW'(slot_q);
	assign prev_ext = XW'(prev_q);

	assign stat.bad_args  = bad_args;
	assign stat.found     = found;
	assign stat.exhausted = !found && (probe_cnt_q == LAST_IDX);
	assign stat.at_null   = nxt_null;
	assign stat.fits      = (rem_rd_q <= time_q);
	assign stat.out_busy  = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			cursor_q    <= '0;
			probe_cnt_q <= '0;
			head_link_q <= NULL_LINK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				probe_cnt_q <= '0;
			if (cmd.probe) begin
				// advance before testing; a miss on every slot wraps back
				cursor_q    <= cand;
				probe_cnt_q <= probe_cnt_q + 1'b1;
				if (found)
					used_q[cand] <= 1'b1;
			end
			if (cmd.link && (prev_q == HEAD_IDX))
				head_link_q <= LW'(slot_q);
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stat_q  <= bad_args ? ST_BAD_ARGS : ST_SCHEDULED;
			time_q  <= in_data[30:0];
			start_q <= in_data[30:0];
			conn_q  <= in_data[39:32];
			type_q  <= in_user[8:1];
		end
		if (cmd.probe) begin
			if (found) begin
				slot_q <= cand;
				prev_q <= HEAD_IDX;
				nxt_q  <= head_link_q;
			end else if (probe_cnt_q == LAST_IDX) begin
				stat_q <= ST_FULL;
			end
		end
		if (cmd.step) begin
			time_q <= time_q - rem_rd_q;
			prev_q <= nxt_idx;
			nxt_q  <= link_rd_q;
		end
		if (cmd.fixup)
			succ_q <= succ_new;
		if (cmd.emit) begin
			out_user_q <= {ok && !nxt_null, stat_q};
			out_data_q <= {(ok && !nxt_null) ? succ_q : 31'd0,
			               ok ? time_q : 31'd0,
			               ok ? prev_ext[4:0] : 5'd0,
			               ok ? slot_ext[4:0] : 5'd0};
		end
	end

	// memories: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rem_rd_q  <= rem_mem[nxt_idx];
			link_rd_q <= link_mem[nxt_idx];
		end
		if (cmd.link) begin
			rem_mem[slot_q]  <= time_q;
			link_mem[slot_q] <= nxt_q;
			rec_mem[slot_q]  <= {start_q, type_q, conn_q};
		end
		if (cmd.fixup) begin
			if (prev_q != HEAD_IDX)
				link_mem[prev_q] <= LW'(slot_q);
			if (!nxt_null)
				rem_mem[nxt_idx] <= succ_new;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	a_head_never_used: assert property (@(posedge clk) disable iff (!arst_n)
		!used_q[HEAD_IDX])
		else $error("head slot marked used");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_user_q[1:0] != ST_SCHEDULED) |-> (out_data_q == '0)
		&& !out_user_q[2])
		else $error("rejected beat carries non-zero fields");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && !out_ready))
		else $error("output register overwritten");

	a_new_slot_unlinked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link |-> (nxt_q != LW'(slot_q)) && (head_link_q != LW'(slot_q)))
		else $error("new slot already in the list");

endmodule

// ----- rtl/delta_queue_timer_insert.sv -----
// Delta-queue timer insert: one result beat per request beat, one request in flight.
// After the accepting edge, bad arguments go straight to the response state; otherwise
// P round-robin probes (one per cycle, up to EVENT_SLOTS) find a free slot or a full table,
// then W entries are walked (read, compare) before the link, fixup and response states.
// s_tready returns as m_tvalid rises, so a new request is taken only once the last is done;
// an untaken result beat holds the next one. Reset clears used flags, head link, cursor, state.
module delta_queue_timer_insert import dqti_pkg::*; #(
	parameter int EVENT_SLOTS = 32,
	parameter int HEAD_SLOT   = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // delay_ms[31:0], conn_id[39:32]
	input  logic [8:0]  s_tuser,  // conn_present[0], event_type[8:1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // slot[4:0], prev_slot[9:5], stored_delta[40:10],
	                              // successor_delta[71:41]
	output logic [2:0]  m_tuser   // status[1:0], has_successor[2]
);

	dqti_cmd_t  cmd;
	dqti_stat_t stat;

	dqti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dqti_dpath #(
		.EVENT_SLOTS (EVENT_SLOTS),
		.HEAD_SLOT   (HEAD_SLOT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for delta_queue_timer_insert: stream requests in, result beats out.
// Keeps its own delta-queue table to predict each result; needs rtl/dqti_pkg.sv, the
// top-level RTL and its controller and datapath.
`timescale 1ns / 1ps

module testbench;
	import dqti_pkg::*;

	localparam int NSLOT      = 32;
	localparam int HEAD_IDX   = 0 % NSLOT;
	localparam int NULL_LINK  = NSLOT;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_OFF   = 400;

	typedef struct packed {
		status_code_t status;
		logic [4:0]   slot;
		logic [4:0]   prev_slot;
		logic [30:0]  stored_delta;
		logic         has_successor;
		logic [30:0]  successor_delta;
	} insert_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // delay_ms[31:0], conn_id[39:32]
	logic [8:0]  s_tuser;  // conn_present[0], event_type[8:1]
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;  // slot[4:0], prev_slot[9:5], stored_delta[40:10],
	                       // successor_delta[71:41]
	logic [2:0]  m_tuser;  // status[1:0], has_successor[2]

	// shadow of the timer table
	bit          slot_used [NSLOT];
	int unsigned slot_next [NSLOT];
	logic [30:0] slot_delta [NSLOT];
	int unsigned rr_cursor;
	int unsigned slots_taken;

	insert_result_t pending_results[$];
	int unsigned    fail_count;
	int unsigned    idle_cycles;
	int unsigned    hold_cycles;
	bit             no_idle;

	delta_queue_timer_insert #(
		.EVENT_SLOTS(NSLOT),
		.HEAD_SLOT  (0)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic clear_timer_table();
		for (int i = 0; i < NSLOT; i++) begin
			slot_used[i]  = 1'b0;
			slot_next[i]  = NULL_LINK;
			slot_delta[i] = '0;
		end
		rr_cursor   = 0;
		slots_taken = 0;
	endtask

	// Take a slot round-robin and link the entry into the delta list.
	function automatic insert_result_t schedule_event(logic [31:0] delay, logic present);
		insert_result_t res;
		logic [30:0]    left;
		int unsigned    slot;
		int unsigned    prev;
		int unsigned    nxt;
		int unsigned    steps;
		bit             found;
		res   = '0;
		found = 1'b0;
		slot  = NULL_LINK;
		if (delay[31] || !present) begin
			res.status = ST_BAD_ARGS;
			return res;
		end
		left = delay[30:0];
		for (int n = 0; n < NSLOT; n++) begin
			if (!found) begin
				rr_cursor = (rr_cursor + 1) % NSLOT;
				if (rr_cursor != HEAD_IDX && !slot_used[rr_cursor]) begin
					found = 1'b1;
					slot  = rr_cursor;
				end
			end
		end
		if (!found) begin
			res.status = ST_FULL;
			return res;
		end
		slot_used[slot] = 1'b1;
		slots_taken++;
		prev  = HEAD_IDX;
		nxt   = slot_next[prev];
		steps = 0;
		// advance past every entry that fires no later than the new one
		while (nxt < NULL_LINK && steps < NSLOT && slot_delta[nxt] <= left) begin
			left  = left - slot_delta[nxt];
			prev  = nxt;
			nxt   = slot_next[nxt];
			steps++;
		end
		slot_next[slot]  = nxt;
		slot_next[prev]  = slot;
		slot_delta[slot] = left;
		res.status       = ST_SCHEDULED;
		res.slot         = slot[4:0];
		res.prev_slot    = prev[4:0];
		res.stored_delta = left;
		if (nxt < NULL_LINK) begin
			slot_delta[nxt]     = slot_delta[nxt] - left;
			res.has_successor   = 1'b1;
			res.successor_delta = slot_delta[nxt];
		end
		return res;
	endfunction

	// Mostly no gap, some short, a few long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_request(input logic [31:0] delay, input logic present,
	                            input logic [7:0] conn, input logic [7:0] kind);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {conn, delay};
		s_tuser  <= {kind, present};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(schedule_event(delay, present));
	endtask

	task automatic send_random_request(input int unsigned valid_pct);
		logic [31:0] raw;
		logic [31:0] delay;
		logic        present;
		int unsigned pick;
		raw  = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < valid_pct) begin
			present = 1'b1;
			case ($urandom_range(0, 5))
				0: delay = $urandom_range(0, 15);
				1: delay = 32'h7FFF_FFFF;
				default: delay = {1'b0, raw[30:0]};
			endcase
		end else if (pick[0]) begin
			delay   = {1'b1, raw[30:0]};
			present = 1'($urandom_range(0, 1));
		end else begin
			delay   = raw;
			present = 1'b0;
		end
		send_request(delay, present, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// Hold the request side until every outstanding result has come back.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic test_bad_arguments();
		send_request(32'hFFFF_FFFF, 1'b1, 8'h5A, 8'hA5);
		send_request(32'h8000_0000, 1'b1, 8'hFF, 8'hFF);
		send_request(32'h8000_0000, 1'b0, 8'h00, 8'h00);
		send_request(32'h0000_0000, 1'b0, 8'h12, 8'h34);
		send_request(32'h7FFF_FFFF, 1'b0, 8'hFF, 8'h00);
	endtask

	task automatic test_directed_inserts();
		send_request(32'd0, 1'b1, 8'h00, 8'h00);          // empty list
		send_request(32'h7FFF_FFFF, 1'b1, 8'hFF, 8'hFF);  // tail, largest delay
		send_request(32'd0, 1'b1, 8'h01, 8'h02);          // tie with the first entry
		send_request(32'd1000, 1'b1, 8'h10, 8'h20);       // successor delta reduced
		send_request(32'd1000, 1'b1, 8'h11, 8'h21);       // tie in the middle
		send_request(32'hFFFF_FFFF, 1'b1, 8'h33, 8'h44);  // rejected, cursor held
		send_request(32'd1, 1'b0, 8'h55, 8'h66);          // no connection, cursor held
		send_request(32'd500, 1'b1, 8'h80, 8'h40);        // lands between entries
		send_request(32'h7FFF_FFFF, 1'b1, 8'h7F, 8'hFE);  // walks the whole list
		send_request(32'd1, 1'b1, 8'hC3, 8'h3C);
		wait_for_results();
	endtask

	// Stall the result side long enough for the request side to back up.
	task automatic test_output_backpressure();
		hold_cycles = HOLD_OFF;
		repeat (10) send_random_request(85);
		wait_for_results();
	endtask

	task automatic test_fill_table();
		while (slots_taken < NSLOT - 1) send_random_request(80);
		wait_for_results();
	endtask

	task automatic test_full_table();
		send_request(32'd0, 1'b1, 8'h00, 8'hFF);
		send_request(32'h7FFF_FFFF, 1'b1, 8'hFF, 8'h00);
		send_request(32'h8000_0000, 1'b1, 8'hAA, 8'h55);
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 560; i++) begin
			if (i == 200)
				no_idle = 1'b1;
			if (i == 300) begin
				no_idle = 1'b0;
				wait_for_results();
			end
			send_random_request(70);
		end
	endtask

	initial begin : ready_driver
		int unsigned stall;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_cycles != 0) begin
				stall       = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = pick_gap();
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		insert_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: tdata %h tuser %h", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser[1:0] !== want.status) begin
					$error("status: expected %0d got %0d", want.status, m_tuser[1:0]);
					fail_count++;
				end
				if (m_tdata[4:0] !== want.slot) begin
					$error("slot: expected %0d got %0d", want.slot, m_tdata[4:0]);
					fail_count++;
				end
				if (m_tdata[9:5] !== want.prev_slot) begin
					$error("prev_slot: expected %0d got %0d", want.prev_slot, m_tdata[9:5]);
					fail_count++;
				end
				if (m_tdata[40:10] !== want.stored_delta) begin
					$error("stored_delta: expected %0d got %0d",
					       want.stored_delta, m_tdata[40:10]);
					fail_count++;
				end
				if (m_tuser[2] !== want.has_successor) begin
					$error("has_successor: expected %0d got %0d",
					       want.has_successor, m_tuser[2]);
					fail_count++;
				end
				if (m_tdata[71:41] !== want.successor_delta) begin
					$error("successor_delta: expected %0d got %0d",
					       want.successor_delta, m_tdata[71:41]);
					fail_count++;
				end
			end
		end
	end

	// Stop a hung run: count cycles with no beat on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		fail_count  = 0;
		idle_cycles = 0;
		hold_cycles = 0;
		no_idle     = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		clear_timer_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bad_arguments();
		test_directed_inserts();
		test_output_backpressure();
		test_fill_table();
		test_full_table();
		test_random_traffic();
		wait_for_results();
		// allow for the slowest insert plus a stray extra beat
		repeat (120) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/dqti_pkg.sv
rtl/dqti_ctrl.sv
rtl/dqti_dpath.sv
rtl/delta_queue_timer_insert.sv
dv/testbench.sv
